// File: sv/weighted_graph_two_hop_route_query_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-hop route query block
// Implication checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_GRAPH_TWO_HOP_ROUTE_QUERY_MACROS_SVH
`define WEIGHTED_GRAPH_TWO_HOP_ROUTE_QUERY_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WGTRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WGTRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WGTRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WGTRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/wgtrq_pkg.sv
// ----------------------------------------------------------------------------
// wgtrq_pkg
// Shared widths, codes, state and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wgtrq_pkg;

  localparam int DEF_MAX_CITIES  = 32;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int CITY_W      = 6;
  localparam int OP_W        = 2;
  localparam int KIND_W      = 3;
  localparam int IN_WEIGHT_W = 16;
  localparam int SUM_W       = 17;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CITY_W-1:0] NUM_CITIES_RST = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_ROUTE = 2'd1,
    OP_NBR   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DIRECT    = 3'd0,
    KIND_NO_DIRECT = 3'd1,
    KIND_VIA       = 3'd2,
    KIND_NO_VIA    = 3'd3,
    KIND_NBR       = 3'd4,
    KIND_NO_NBR    = 3'd5,
    KIND_BAD       = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_BAD,
    ST_DIRECT_RD,
    ST_DIRECT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // source of a result loaded into the output register
  typedef enum logic [1:0] {
    OSEL_BAD,
    OSEL_DIRECT,
    OSEL_PEND,
    OSEL_NONE
  } out_sel_t;

  typedef struct packed {
    logic     load;       // input transfer: latch item, restart scan
    logic     clr_we;     // clearing pass: zero one entry, step address
    logic     edge_we;    // store edge weights
    logic     rd_direct;  // read entry (source, dest)
    logic     rd_scan;    // read candidate k, step k
    logic     consume;    // evaluated candidate retired
    logic     pend_load;  // hit goes to pending register
    logic     pend_clr;
    logic     push;       // load output register
    out_sel_t out_sel;
    logic     push_last;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic bad;
    logic clr_last;
    logic k_end;
    logic rd_v;
    logic hit;
    logic pend_v;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/weighted_graph_two_hop_route_query.sv
// ----------------------------------------------------------------------------
// weighted_graph_two_hop_route_query
// Directed weighted adjacency store (time, fuel) with direct, one-stop and
// neighbour queries over city codes 1..num_cities.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            contents
//  in_      in   tvalid/tready        item: op, source, dest, time, fuel
//  out_     out  tvalid/tready/tlast  result: kind, city, total time/fuel
//  cfg_     in   we (no ready)        num_cities
//
//  Per item (n = effective city count): an edge write, a bad code or an
//    unused op needs no scan; a neighbour query scans cities 1..n, and a
//    route query reads the direct entry first and then scans. The result
//    side can stall any item that answers. The scan reads one candidate
//    city per cycle from the weight RAM unless a new hit waits (see below);
//    a route query uses both read ports (source->k and k->dest) in the same cycle.
//  One hit is held back in a pending register so the final result can
//    carry tlast; a new hit waits only if that register is full and the
//    output register cannot take a result.
//  After reset a clearing pass zeroes the RAM, one entry per cycle, over
//    4**clog2(MAX_CITIES) entries (1024 at 32 cities); in_tready stays low
//    throughout, configuration writes are taken.
//  An input transfer is taken while the previous result still waits in the
//    output register.
// ----------------------------------------------------------------------------
module weighted_graph_two_hop_route_query #(
  parameter int MAX_CITIES  = wgtrq_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = wgtrq_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] op
  input  logic [wgtrq_pkg::OP_W-1:0]        in_tuser,
  // [5:0] source_city, [11:6] dest_city, [27:12] edge_time,
  // [43:28] edge_fuel, [47:44] zero
  input  logic [wgtrq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] kind
  output logic [wgtrq_pkg::KIND_W-1:0]      out_tuser,
  // [5:0] city, [22:6] total_time, [39:23] total_fuel
  output logic [wgtrq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  // [5:0] num_cities
  input  logic [wgtrq_pkg::CITY_W-1:0]      cfg_wdata
);
  import wgtrq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: issues one command word per cycle from datapath status
  wgtrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: weight RAM, counters, pending and output registers
  wgtrq_dp #(
    .MAX_CITIES  (MAX_CITIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// File: sv/wgtrq_ram.sv
// ----------------------------------------------------------------------------
// wgtrq_ram
// Generic RAM, one write port, two read ports, registered read with enable.
// ----------------------------------------------------------------------------
module wgtrq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: sv/wgtrq_ctrl.sv
// ----------------------------------------------------------------------------
// wgtrq_ctrl
// Sequencer: clearing pass, decode, edge write, direct read, candidate scan.
// ----------------------------------------------------------------------------
module wgtrq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  wgtrq_pkg::dp_stat_t stat,
  output wgtrq_pkg::dp_cmd_t  cmd
);
  import wgtrq_pkg::*;

  state_t state_r, state_nxt;
  logic   stall;

  // scan holds when a new hit must evict the pending result but output is busy
  assign stall = stat.rd_v && stat.hit && stat.pend_v && !stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.op == OP_NONE) begin
          state_nxt = ST_IDLE;
        end else if (stat.bad) begin
          state_nxt = ST_BAD;
        end else begin
          case (stat.op)
            OP_WRITE: state_nxt = ST_WRITE;
            OP_ROUTE: state_nxt = ST_DIRECT_RD;
            OP_NBR:   state_nxt = ST_SCAN;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:     state_nxt = ST_IDLE;
      ST_BAD: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_DIRECT_RD: state_nxt = ST_DIRECT;
      ST_DIRECT: begin
        if (stat.out_free) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall && stat.k_end) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.out_sel   = OSEL_BAD;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WRITE: begin
        cmd.edge_we = 1'b1;
      end
      ST_BAD: begin
        cmd.push      = stat.out_free;
        cmd.out_sel   = OSEL_BAD;
        cmd.push_last = 1'b1;
      end
      ST_DIRECT_RD: begin
        cmd.rd_direct = 1'b1;
      end
      ST_DIRECT: begin
        cmd.push    = stat.out_free;
        cmd.out_sel = OSEL_DIRECT;
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.consume   = stat.rd_v;
          cmd.pend_load = stat.rd_v && stat.hit;
          cmd.push      = stat.rd_v && stat.hit && stat.pend_v;
          cmd.rd_scan   = !stat.k_end;
        end
        cmd.out_sel = OSEL_PEND;
      end
      ST_FINISH: begin
        cmd.push      = stat.out_free;
        cmd.out_sel   = stat.pend_v ? OSEL_PEND : OSEL_NONE;
        cmd.push_last = 1'b1;
        cmd.pend_clr  = stat.out_free;
      end
      default: begin
        cmd.out_sel = OSEL_BAD;
      end
    endcase
  end

endmodule

// File: sv/wgtrq_dp.sv
// ----------------------------------------------------------------------------
// wgtrq_dp
// Item registers, weight RAM, scan counters, pending and output registers.
// ----------------------------------------------------------------------------
`include "weighted_graph_two_hop_route_query_macros.svh"

module wgtrq_dp #(
  parameter int MAX_CITIES  = wgtrq_pkg::DEF_MAX_CITIES,
  parameter int WEIGHT_BITS = wgtrq_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [wgtrq_pkg::OP_W-1:0]           in_tuser,
  input  logic [wgtrq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wgtrq_pkg::KIND_W-1:0]         out_tuser,
  output logic [wgtrq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [wgtrq_pkg::CITY_W-1:0]         cfg_wdata,
  input  wgtrq_pkg::dp_cmd_t                   cmd,
  output wgtrq_pkg::dp_stat_t                  stat
);
  import wgtrq_pkg::*;

  localparam int IDX_W  = $clog2(MAX_CITIES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int WORD_W = 2 * WEIGHT_BITS;
  localparam logic [CITY_W-1:0] MAX_C = CITY_W'(MAX_CITIES);

  // configuration
  logic [CITY_W-1:0] ncfg_r;
  logic [CITY_W-1:0] n_eff;

  // latched item
  op_t                    op_r;
  logic [CITY_W-1:0]      s_r, d_r;
  logic [IN_WEIGHT_W-1:0] et_r, ef_r;

  // counters
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CITY_W:0]   k_r;
  logic [CITY_W-1:0] ke_r;
  logic              rd_v_r;

  // pending result
  logic              pend_v_r;
  kind_t             pend_kind_r;
  logic [CITY_W-1:0] pend_city_r;
  logic [SUM_W-1:0]  pend_time_r, pend_fuel_r;

  // output register
  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [CITY_W-1:0] out_city_r;
  logic [SUM_W-1:0]  out_time_r, out_fuel_r;
  logic              out_last_r;
  kind_t             o_kind;
  logic [CITY_W-1:0] o_city;
  logic [SUM_W-1:0]  o_time, o_fuel;
  logic              o_last;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, addr_a, addr_b;
  logic [WORD_W-1:0] ram_wdata, rdata_a, rdata_b;
  logic [CITY_W-1:0] s_m1, d_m1, k_m1;

  // evaluation
  logic [WEIGHT_BITS-1:0] t1, f1, t2, f2;
  logic [WEIGHT_BITS:0]   sum_t, sum_f;
  logic                   is_route, hit;
  logic                   s_ok, d_ok, out_free, k_end;

  assign n_eff = (ncfg_r > MAX_C) ? MAX_C : ncfg_r;

  assign s_m1 = s_r - CITY_W'(1);
  assign d_m1 = d_r - CITY_W'(1);
  assign k_m1 = k_r[CITY_W-1:0] - CITY_W'(1);

  assign addr_a = cmd.rd_direct ? {s_m1[IDX_W-1:0], d_m1[IDX_W-1:0]}
                                : {s_m1[IDX_W-1:0], k_m1[IDX_W-1:0]};
  assign addr_b = {k_m1[IDX_W-1:0], d_m1[IDX_W-1:0]};

  assign ram_we    = cmd.clr_we || cmd.edge_we;
  assign ram_waddr = cmd.clr_we ? clr_addr_r : {s_m1[IDX_W-1:0], d_m1[IDX_W-1:0]};
  assign ram_wdata = cmd.clr_we ? '0 : {WEIGHT_BITS'(ef_r), WEIGHT_BITS'(et_r)};

  wgtrq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (cmd.rd_direct || cmd.rd_scan),
    .raddr_a (addr_a),
    .rdata_a (rdata_a),
    .re_b    (cmd.rd_scan),
    .raddr_b (addr_b),
    .rdata_b (rdata_b)
  );

  assign t1 = rdata_a[WEIGHT_BITS-1:0];
  assign f1 = rdata_a[WORD_W-1:WEIGHT_BITS];
  assign t2 = rdata_b[WEIGHT_BITS-1:0];
  assign f2 = rdata_b[WORD_W-1:WEIGHT_BITS];

  assign is_route = (op_r == OP_ROUTE);

  // route: both legs present, stop differs from both ends; neighbour: edge present
  assign hit = is_route ? ((ke_r != s_r) && (ke_r != d_r) && (t1 != '0) && (t2 != '0))
                        : (t1 != '0);

  assign sum_t = {1'b0, t1} + (is_route ? {1'b0, t2} : '0);
  assign sum_f = {1'b0, f1} + (is_route ? {1'b0, f2} : '0);

  assign s_ok     = (s_r != '0) && (s_r <= n_eff);
  assign d_ok     = (d_r != '0) && (d_r <= n_eff);
  assign out_free = !out_vld_r || out_tready;
  assign k_end    = k_r > {1'b0, n_eff};

  assign stat.op       = op_r;
  assign stat.bad      = !s_ok || ((op_r != OP_NBR) && !d_ok);
  assign stat.clr_last = &clr_addr_r;
  assign stat.k_end    = k_end;
  assign stat.rd_v     = rd_v_r;
  assign stat.hit      = hit;
  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = out_free;

  always_comb begin
    o_kind = KIND_BAD;
    o_city = '0;
    o_time = '0;
    o_fuel = '0;
    o_last = 1'b1;
    case (cmd.out_sel)
      OSEL_BAD: begin
        o_kind = KIND_BAD;
      end
      OSEL_DIRECT: begin
        o_last = 1'b0;
        if (t1 != '0) begin
          o_kind = KIND_DIRECT;
          o_time = SUM_W'(t1);
          o_fuel = SUM_W'(f1);
        end else begin
          o_kind = KIND_NO_DIRECT;
        end
      end
      OSEL_PEND: begin
        o_kind = pend_kind_r;
        o_city = pend_city_r;
        o_time = pend_time_r;
        o_fuel = pend_fuel_r;
        o_last = cmd.push_last;
      end
      OSEL_NONE: begin
        o_kind = is_route ? KIND_NO_VIA : KIND_NO_NBR;
      end
      default: begin
        o_kind = KIND_BAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncfg_r     <= NUM_CITIES_RST;
      clr_addr_r <= '0;
      k_r        <= '0;
      rd_v_r     <= 1'b0;
      pend_v_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) ncfg_r <= cfg_wdata;
      if (cmd.clr_we) clr_addr_r <= clr_addr_r + ADDR_W'(1);

      if (cmd.load) begin
        k_r <= (CITY_W + 1)'(1);
      end else if (cmd.rd_scan) begin
        k_r <= k_r + (CITY_W + 1)'(1);
      end

      if (cmd.load) begin
        rd_v_r <= 1'b0;
      end else if (cmd.rd_scan) begin
        rd_v_r <= 1'b1;
      end else if (cmd.consume) begin
        rd_v_r <= 1'b0;
      end

      if (cmd.load || cmd.pend_clr) begin
        pend_v_r <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_v_r <= 1'b1;
      end

      if (cmd.push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(in_tuser);
      s_r  <= in_tdata[CITY_W-1:0];
      d_r  <= in_tdata[2*CITY_W-1:CITY_W];
      et_r <= in_tdata[2*CITY_W+IN_WEIGHT_W-1:2*CITY_W];
      ef_r <= in_tdata[2*CITY_W+2*IN_WEIGHT_W-1:2*CITY_W+IN_WEIGHT_W];
    end
    if (cmd.rd_scan) ke_r <= k_r[CITY_W-1:0];
    if (cmd.pend_load) begin
      pend_kind_r <= is_route ? KIND_VIA : KIND_NBR;
      pend_city_r <= ke_r;
      pend_time_r <= SUM_W'(sum_t);
      pend_fuel_r <= SUM_W'(sum_f);
    end
    if (cmd.push) begin
      out_kind_r <= o_kind;
      out_city_r <= o_city;
      out_time_r <= o_time;
      out_fuel_r <= o_fuel;
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_fuel_r, out_time_r, out_city_r};
  assign out_tlast  = out_last_r;

  `WGTRQ_ASSERT_IMP(a_push_free, clk, rst_n, cmd.push, out_free, "push into busy output")
  `WGTRQ_ASSERT_IMP(a_pend_evict, clk, rst_n, cmd.pend_load && pend_v_r,
                    cmd.push && (cmd.out_sel == OSEL_PEND), "pending result overwritten")
  `WGTRQ_ASSERT_IMP(a_pend_src, clk, rst_n, cmd.push && (cmd.out_sel == OSEL_PEND),
                    pend_v_r, "empty pending result pushed")
  `WGTRQ_ASSERT_NXT(a_scan_bound, clk, rst_n, cmd.rd_scan,
                    ke_r <= n_eff, "scan read beyond city count")

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: two-hop route query bench
// Drives edge writes, route queries and neighbour queries through the input
// stream, keeps its own copy of the time/fuel tables and the city count,
// and checks every output transfer field by field against the predicted
// answer lines. Random idling on both sides, one long output hold.
// ----------------------------------------------------------------------------
module tb;
  import wgtrq_pkg::*;

  localparam int MAX_C      = DEF_MAX_CITIES;
  localparam int IDLE_GUARD = 48;  // outlasts a route query scan at 32 cities

  // one line of a query answer
  typedef struct {
    kind_t             kind;
    logic [CITY_W-1:0] city;
    logic [SUM_W-1:0]  hours;
    logic [SUM_W-1:0]  litres;
    logic              last;
  } answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OP_W-1:0]        in_tuser = '0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [KIND_W-1:0]      out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CITY_W-1:0]      cfg_wdata = '0;

  // bench copy of the block state
  logic [IN_WEIGHT_W-1:0] hours_tab  [0:MAX_C][0:MAX_C];
  logic [IN_WEIGHT_W-1:0] litres_tab [0:MAX_C][0:MAX_C];
  logic [CITY_W-1:0]      city_cfg;

  answer_t expected_answers[$];
  int      errors = 0;
  bit      idle_en = 1'b1;   // random gaps on both sides
  int      sink_hold = 0;    // request for one long output hold, in cycles

  weighted_graph_two_hop_route_query uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic int live_cities();
    return (city_cfg > MAX_C) ? MAX_C : int'(city_cfg);
  endfunction

  // Apply one accepted item to the table copy and queue the answer lines.
  function automatic void predict_route_answer(input op_t op,
                                               input logic [CITY_W-1:0] src, dst,
                                               input logic [IN_WEIGHT_W-1:0] hrs, ltr);
    answer_t batch[$];
    answer_t a;
    int      n;
    int      s;
    int      d;
    bit      s_ok;
    bit      d_ok;
    n = live_cities();
    s = int'(src);
    d = int'(dst);
    s_ok = (s >= 1) && (s <= n);
    d_ok = (d >= 1) && (d <= n);
    a.city = '0;
    a.hours = '0;
    a.litres = '0;
    a.last = 1'b0;
    if (op == OP_NONE)
      return;
    if (!s_ok || (op != OP_NBR && !d_ok)) begin
      a.kind = KIND_BAD;
      batch.push_back(a);
    end else if (op == OP_WRITE) begin
      // fuel lands even when the time clears the edge
      hours_tab[s][d]  = hrs;
      litres_tab[s][d] = ltr;
    end else if (op == OP_ROUTE) begin
      if (hours_tab[s][d] != '0) begin
        a.kind   = KIND_DIRECT;
        a.hours  = {1'b0, hours_tab[s][d]};
        a.litres = {1'b0, litres_tab[s][d]};
      end else
        a.kind = KIND_NO_DIRECT;
      batch.push_back(a);
      // stop city must differ from both ends
      for (int k = 1; k <= n; k++) begin
        if (k != s && k != d && hours_tab[s][k] != '0 && hours_tab[k][d] != '0) begin
          a.kind   = KIND_VIA;
          a.city   = CITY_W'(k);
          a.hours  = {1'b0, hours_tab[s][k]} + {1'b0, hours_tab[k][d]};
          a.litres = {1'b0, litres_tab[s][k]} + {1'b0, litres_tab[k][d]};
          batch.push_back(a);
        end
      end
      if (batch.size() == 1) begin
        a.kind = KIND_NO_VIA;
        a.city = '0;
        a.hours = '0;
        a.litres = '0;
        batch.push_back(a);
      end
    end else begin
      for (int k = 1; k <= n; k++) begin
        if (hours_tab[s][k] != '0) begin
          a.kind   = KIND_NBR;
          a.city   = CITY_W'(k);
          a.hours  = {1'b0, hours_tab[s][k]};
          a.litres = {1'b0, litres_tab[s][k]};
          batch.push_back(a);
        end
      end
      if (batch.size() == 0) begin
        a.kind = KIND_NO_NBR;
        batch.push_back(a);
      end
    end
    foreach (batch[i]) begin
      a = batch[i];
      a.last = (i == batch.size() - 1);
      expected_answers.push_back(a);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready gaps plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold - 1) @(negedge clk);
        sink_hold = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else
        out_tready <= 1'b1;
    end
  end

  // compare every output transfer with the oldest queued line
  always @(posedge clk) begin : result_checker
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: kind %0d city %0d", out_tuser, out_tdata[5:0]);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[5:0] !== want.city) begin
          $error("city: expected %0d, actual %0d", want.city, out_tdata[5:0]);
          errors++;
        end
        if (out_tdata[22:6] !== want.hours) begin
          $error("total_time: expected %0d, actual %0d", want.hours, out_tdata[22:6]);
          errors++;
        end
        if (out_tdata[39:23] !== want.litres) begin
          $error("total_fuel: expected %0d, actual %0d", want.litres, out_tdata[39:23]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // One input transfer; valid stays up after acceptance until the next
  // falling edge decides whether another item follows.
  task automatic send_request(input op_t op, input logic [CITY_W-1:0] src, dst,
                              input logic [IN_WEIGHT_W-1:0] hrs, ltr);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, ltr, hrs, dst, src};
    do @(posedge clk); while (!in_tready);
    predict_route_answer(op, src, dst, hrs, ltr);
  endtask

  // drop valid, let every queued line arrive, then cover a trailing write
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
  endtask

  task automatic write_city_count(input logic [CITY_W-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    city_cfg  = value;
  endtask

  // mostly codes among the first few cities for a dense graph, some stray codes
  function automatic logic [CITY_W-1:0] pick_city(input int n);
    int roll;
    roll = $urandom_range(0, 99);
    if (n == 0 || roll < 6)
      return CITY_W'($urandom_range(0, 63));
    if (roll < 55)
      return CITY_W'($urandom_range(1, (n < 6) ? n : 6));
    return CITY_W'($urandom_range(1, n));
  endfunction

  // mix of writes and queries; unused-op items are extra and not counted
  task automatic random_traffic(input int count);
    int   done;
    int   roll;
    int   n;
    op_t  op;
    logic [IN_WEIGHT_W-1:0] hrs;
    done = 0;
    n = live_cities();
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4)
        op = OP_NONE;
      else if (roll < 46)
        op = OP_WRITE;
      else if (roll < 76)
        op = OP_ROUTE;
      else
        op = OP_NBR;
      hrs = ($urandom_range(0, 6) == 0) ? '0 : IN_WEIGHT_W'($urandom_range(1, 65535));
      send_request(op, pick_city(n), pick_city(n), hrs,
                   IN_WEIGHT_W'($urandom_range(0, 65535)));
      if (op != OP_NONE)
        done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_tables();
    send_request(OP_ROUTE, 6'd1, 6'd2, '0, '0);
    send_request(OP_NBR, 6'd1, 6'd0, '0, '0);
  endtask

  task automatic test_bad_codes();
    send_request(OP_ROUTE, 6'd0, 6'd2, '0, '0);
    send_request(OP_ROUTE, 6'd3, 6'd33, '0, '0);
    send_request(OP_WRITE, 6'd40, 6'd1, 16'hFFFF, 16'hFFFF);  // must not land
    send_request(OP_NBR, 6'd63, 6'd0, '0, '0);
    send_request(OP_NBR, 6'd1, 6'd0, '0, '0);    // dest ignored here
    send_request(OP_NONE, 6'd0, 6'd63, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_weights_and_stops();
    // full-scale legs: the sum needs the whole 17-bit field
    send_request(OP_WRITE, 6'd1, 6'd2, 16'hFFFF, 16'hFFFF);
    send_request(OP_WRITE, 6'd2, 6'd3, 16'hFFFF, 16'hFFFF);
    send_request(OP_ROUTE, 6'd1, 6'd3, '0, '0);
    send_request(OP_WRITE, 6'd1, 6'd3, 16'd1, 16'd0);
    send_request(OP_ROUTE, 6'd1, 6'd3, '0, '0);
    // self edge shows up as the direct line
    send_request(OP_WRITE, 6'd1, 6'd1, 16'd7, 16'd9);
    send_request(OP_ROUTE, 6'd1, 6'd1, '0, '0);
    send_request(OP_WRITE, 6'd2, 6'd1, 16'd3, 16'd4);
    send_request(OP_ROUTE, 6'd1, 6'd1, '0, '0);
    // zero time removes the edge, fuel still written
    send_request(OP_WRITE, 6'd1, 6'd2, 16'd0, 16'd500);
    send_request(OP_ROUTE, 6'd1, 6'd3, '0, '0);
    send_request(OP_NBR, 6'd1, 6'd0, '0, '0);
  endtask

  task automatic test_city_count_extremes();
    write_city_count(6'd1);
    send_request(OP_ROUTE, 6'd1, 6'd1, '0, '0);
    send_request(OP_NBR, 6'd1, 6'd0, '0, '0);
    send_request(OP_ROUTE, 6'd1, 6'd2, '0, '0);
    write_city_count(6'd0);          // every code bad
    send_request(OP_NBR, 6'd1, 6'd0, '0, '0);
    write_city_count(6'd63);         // clamps to the table size
    send_request(OP_ROUTE, 6'd32, 6'd32, '0, '0);
    send_request(OP_NBR, 6'd33, 6'd0, '0, '0);
  endtask

  task automatic test_random_dense();
    write_city_count(6'd6);
    random_traffic(120);
  endtask

  // output held for a long stretch while queries keep coming: the block
  // fills and must stall its input, nothing may be lost
  task automatic test_output_backpressure();
    wait_idle();
    sink_hold = 300;
    for (int i = 0; i < 10; i++)
      send_request((i % 3 == 2) ? OP_NBR : OP_ROUTE, CITY_W'($urandom_range(1, 6)),
                   CITY_W'($urandom_range(1, 6)), '0, '0);
    wait_idle();
  endtask

  task automatic test_random_wide();
    write_city_count(6'd32);
    random_traffic(80);
  endtask

  task automatic test_random_mixed_counts();
    for (int p = 0; p < 4; p++) begin
      write_city_count((p == 3) ? 6'd2 : CITY_W'($urandom_range(3, 12)));
      random_traffic(20);
    end
  endtask

  task automatic test_no_idle_tail();
    write_city_count(6'd63);
    idle_en = 1'b0;
    random_traffic(80);
  endtask

  initial begin : sequencer
    for (int i = 0; i <= MAX_C; i++)
      for (int j = 0; j <= MAX_C; j++) begin
        hours_tab[i][j]  = '0;
        litres_tab[i][j] = '0;
      end
    city_cfg = NUM_CITIES_RST;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // first transfers wait out the clearing pass on in_tready

    test_empty_tables();
    test_bad_codes();
    test_weights_and_stops();
    test_city_count_extremes();
    test_random_dense();
    test_output_backpressure();
    test_random_wide();
    test_random_mixed_counts();
    test_no_idle_tail();
    wait_idle();

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/wgtrq_pkg.sv
sv/wgtrq_ram.sv
sv/wgtrq_ctrl.sv
sv/wgtrq_dp.sv
sv/weighted_graph_two_hop_route_query.sv
bench/tb.sv
